@@ hdl/sdq_pkg.sv @@
package sdq_pkg;

  typedef enum logic [2:0] {
    FUNC_INSERT = 3'd0,
    FUNC_PUSH_TAIL = 3'd1,
    FUNC_PUSH_HEAD = 3'd2,
    FUNC_POP_TAIL = 3'd3,
    FUNC_TAKE = 3'd4,
    FUNC_EXISTS = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NOKEY = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0] func;
    logic signed [31:0] key;
    logic [15:0] handle;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic found;
    logic signed [31:0] out_key;
    logic [15:0] out_handle;
    logic [4:0] count;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture request, reset walk index to zero
    logic rd;        // issue read at the walk index
    logic step;      // advance walk index
    logic shift_up;  // move entry idx-1 to idx, walk downward
    logic shift_dn;  // move entry idx+1 to idx, walk upward
    logic place;     // write request at idx, count + 1
    logic pop;       // read tail entry at count - 1, idx := count
    logic take;      // capture handle at idx
    logic dec;       // count - 1
    logic set_tail;  // idx := count (for shift_up start)
    logic set_pos;   // pos := idx (found position)
    logic respond;
    logic [1:0] status;
    logic found;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic at_end;    // walk index reached count
    logic hit_ge;    // stored key at idx <= request key
    logic hit_eq;    // stored key at idx equals request key
    logic up_done;   // shift_up reached the insertion position
    logic dn_done;   // shift_dn reached the tail
    logic [2:0] func;
  } sts_t;

endpackage

@@ hdl/sdq_datapath.sv @@
module sdq_datapath
  import sdq_pkg::*;
#(
  parameter int Capacity = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic valid_o,
  output rsp_t rsp_o
);
  localparam int IW = $clog2(Capacity);
  localparam int CW = $clog2(Capacity + 1);

  logic [31:0] key_mem [Capacity];
  logic [15:0] hdl_mem [Capacity];

  req_t req_q;
  logic [CW-1:0] cnt_q, idx_q, pos_q;
  logic [31:0] rkey_q;
  logic [15:0] rhdl_q;
  logic [31:0] okey_q;
  logic [15:0] ohdl_q;
  logic valid_q;
  rsp_t rsp_q;

  logic [CW-1:0] idx_m1, idx_p1, cnt_m1;
  assign idx_m1 = idx_q - CW'(1);
  assign idx_p1 = idx_q + CW'(1);
  assign cnt_m1 = cnt_q - CW'(1);

  // Memory read port: registered data at the selected address.
  logic [IW-1:0] raddr;
  always_comb begin
    raddr = idx_q[IW-1:0];
    if (cmd_i.shift_up) begin
      raddr = idx_m1[IW-1:0];
    end else if (cmd_i.shift_dn) begin
      raddr = idx_p1[IW-1:0];
    end else if (cmd_i.pop) begin
      raddr = cnt_m1[IW-1:0];
    end
  end

  // Each shift step is a read phase followed by a write phase; the datapath
  // alternates between them using a phase bit.
  logic ph_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd || cmd_i.pop || ((cmd_i.shift_up || cmd_i.shift_dn) && !ph_q)) begin
      rkey_q <= key_mem[raddr];
      rhdl_q <= hdl_mem[raddr];
    end
    if ((cmd_i.shift_up || cmd_i.shift_dn) && ph_q) begin
      key_mem[idx_q[IW-1:0]] <= rkey_q;
      hdl_mem[idx_q[IW-1:0]] <= rhdl_q;
    end else if (cmd_i.place) begin
      key_mem[idx_q[IW-1:0]] <= req_q.key;
      hdl_mem[idx_q[IW-1:0]] <= req_q.handle;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.set_pos) begin
      pos_q <= idx_q;
    end
    if (cmd_i.respond) begin
      rsp_q.status <= cmd_i.status;
      rsp_q.found <= cmd_i.found;
      rsp_q.out_key <= okey_q;
      rsp_q.out_handle <= ohdl_q;
      rsp_q.count <= 5'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      ph_q <= 1'b0;
      valid_q <= 1'b0;
      okey_q <= '0;
      ohdl_q <= '0;
    end else begin
      valid_q <= cmd_i.respond;
      if (cmd_i.load) begin
        idx_q <= '0;
        ph_q <= 1'b0;
        okey_q <= '0;
        ohdl_q <= '0;
      end else if (cmd_i.set_tail) begin
        idx_q <= cnt_q;
        ph_q <= 1'b0;
      end else if (cmd_i.shift_up) begin
        ph_q <= !ph_q;
        if (ph_q) begin
          idx_q <= idx_m1;
        end
      end else if (cmd_i.shift_dn) begin
        ph_q <= !ph_q;
        if (ph_q) begin
          idx_q <= idx_p1;
        end
      end else if (cmd_i.step) begin
        idx_q <= idx_p1;
      end
      if (cmd_i.set_pos) begin
        ph_q <= 1'b0;
      end
      if (cmd_i.place) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.pop) begin
        idx_q <= cnt_q;
      end
      if (cmd_i.dec) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.take) begin
        ohdl_q <= rhdl_q;
      end
      if (cmd_i.found && cmd_i.respond && req_q.func == FUNC_POP_TAIL) begin
        okey_q <= rkey_q;
      end
    end
  end

  assign sts_o.full = (cnt_q >= CW'(Capacity));
  assign sts_o.empty = (cnt_q == '0);
  assign sts_o.at_end = (idx_q >= cnt_q);
  assign sts_o.hit_ge = ($signed(req_q.key) >= $signed(rkey_q));
  assign sts_o.hit_eq = (req_q.key == rkey_q);
  assign sts_o.up_done = (idx_q == pos_q) && !ph_q;
  assign sts_o.dn_done = (idx_p1 >= cnt_q) && !ph_q;
  assign sts_o.func = req_q.func;

  assign valid_o = valid_q;
  always_comb begin
    rsp_o = rsp_q;
    if (req_q.func == FUNC_POP_TAIL && rsp_q.found) begin
      rsp_o.out_key = rkey_q;
      rsp_o.out_handle = rhdl_q;
    end
  end
endmodule

@@ hdl/sdq_ctrl.sv @@
module sdq_ctrl
  import sdq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DISP   = 9'b000000010,
    S_RD     = 9'b000000100,
    S_CMP    = 9'b000001000,
    S_SHUP   = 9'b000010000,
    S_PLACE  = 9'b000100000,
    S_SHDN   = 9'b001000000,
    S_POPW   = 9'b010000000,
    S_RESP   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] st_q, st_d;
  logic fnd_q, fnd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q <= ST_OK;
      fnd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q <= st_d;
      fnd_q <= fnd_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    st_d = st_q;
    fnd_d = fnd_q;
    cmd_o = '0;
    cmd_o.status = st_q;
    cmd_o.found = fnd_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          st_d = ST_OK;
          fnd_d = 1'b0;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.func)
          FUNC_INSERT, FUNC_PUSH_TAIL, FUNC_PUSH_HEAD: begin
            if (sts_i.full) begin
              st_d = ST_FULL;
              state_d = S_RESP;
            end else if (sts_i.func == FUNC_INSERT) begin
              state_d = S_RD;
            end else if (sts_i.func == FUNC_PUSH_TAIL) begin
              cmd_o.set_tail = 1'b1;
              cmd_o.set_pos = 1'b1;
              state_d = S_PLACE;
            end else begin
              // Head push: insertion position is zero, shifting starts at the tail.
              cmd_o.set_pos = 1'b1;
              cmd_o.set_tail = 1'b1;
              state_d = S_SHUP;
            end
          end
          FUNC_POP_TAIL: begin
            if (sts_i.empty) begin
              st_d = ST_EMPTY;
              state_d = S_RESP;
            end else begin
              cmd_o.pop = 1'b1;
              state_d = S_POPW;
            end
          end
          FUNC_TAKE, FUNC_EXISTS: begin
            state_d = S_RD;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_RD: begin
        if (sts_i.at_end) begin
          if (sts_i.func == FUNC_INSERT) begin
            cmd_o.set_pos = 1'b1;
            state_d = S_PLACE;
          end else begin
            st_d = ST_NOKEY;
            state_d = S_RESP;
          end
        end else begin
          cmd_o.rd = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.func == FUNC_INSERT) begin
          if (sts_i.hit_ge) begin
            cmd_o.set_pos = 1'b1;
            cmd_o.set_tail = 1'b1;
            state_d = S_SHUP;
          end else begin
            cmd_o.step = 1'b1;
            state_d = S_RD;
          end
        end else if (sts_i.hit_eq) begin
          fnd_d = 1'b1;
          if (sts_i.func == FUNC_TAKE) begin
            cmd_o.take = 1'b1;
            state_d = S_SHDN;
          end else begin
            state_d = S_RESP;
          end
        end else begin
          cmd_o.step = 1'b1;
          state_d = S_RD;
        end
      end
      S_SHUP: begin
        // Walk down from the tail, moving each entry up by one.
        if (sts_i.up_done) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.shift_up = 1'b1;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d = S_RESP;
      end
      S_SHDN: begin
        if (sts_i.dn_done) begin
          cmd_o.dec = 1'b1;
          state_d = S_RESP;
        end else begin
          cmd_o.shift_dn = 1'b1;
        end
      end
      S_POPW: begin
        cmd_o.dec = 1'b1;
        fnd_d = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        cmd_o.respond = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end
endmodule

@@ hdl/sorted_deque_scheduler_queue_unit.sv @@
// Channel  | Ports                        | Transaction
// ---------+------------------------------+--------------------------------
// request  | start_i, busy_o, req_i       | start_i high while busy_o low
// result   | done_o, rsp_o                | done_o high for one cycle
//
// One request is handled at a time. A pop passes through the dispatch,
// pop-wait and response states; full, empty and unused-code cases go from
// dispatch straight to the response. A sorted insert, take or exists walks
// the store one entry at a time, and moving entries reads and then writes
// each entry, all through one read and one write port of the entry memory.
// Reset clears the count but not the entries; entries above the count are never read.
// The result cannot be stalled: it is shown for exactly one cycle.
module sorted_deque_scheduler_queue_unit
  import sdq_pkg::*;
#(
  parameter int Capacity = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);
  cmd_t cmd;
  sts_t sts;

  // The controller sequences the walk and shifts; the datapath holds the
  // entry memory, the count and the walk index.
  sdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  sdq_datapath #(
    .Capacity(Capacity)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .valid_o(done_o),
    .rsp_o  (rsp_o)
  );
endmodule
